@@ sv/hlge_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hlge_pkg: shared types and constants of the HighLife generation engine
// Item and result beat formats, item kinds, register indexes, controller
// states and the B36/S23 cell update rule.
// ============================================================================
package hlge_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_STEP  = 2'd2;
	localparam logic [1:0] KIND_NOP   = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	localparam logic [7:0] ROWS_RESET = 8'd80;
	localparam logic [8:0] COLS_RESET = 9'd150;

	// Neighbor counts of the HighLife rule.
	localparam logic [3:0] SURVIVE_LO = 4'd2;
	localparam logic [3:0] SURVIVE_HI = 4'd3;
	localparam logic [3:0] BIRTH_LO   = 4'd3;
	localparam logic [3:0] BIRTH_HI   = 4'd6;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] row;
		logic [7:0] col;
		logic       alive_in;
	} req_t;

	typedef struct packed {
		logic cell_alive;
		logic out_of_range;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	// Next value of one cell from its present value and live neighbor count.
	function automatic logic hl_next(input logic alive, input logic [3:0] n);
		if (alive)
			return (n == SURVIVE_LO) || (n == SURVIVE_HI);
		return (n == BIRTH_LO) || (n == BIRTH_HI);
	endfunction

endpackage

@@ sv/highlife_generation_engine.sv @@
`timescale 1ns / 1ps
// ============================================================================
// highlife_generation_engine: HighLife (B36/S23) cellular automaton
// Keeps two planes of one-bit cells in a row-wide memory and writes, reads
// or advances the grid, one item at a time.
// ============================================================================
// Items are taken one at a time: a write or read, an out-of-range or no-op
// item and an advance each run to completion before the next is accepted;
// an advance reads one source row and writes one destination row per cycle.
// A result waits in FINISH until the output register is free.
// Reset clears the memory to dead, one row per cycle, before the first item
// is accepted.
module highlife_generation_engine #(
	parameter int MAX_ROWS = 128,
	parameter int MAX_COLS = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	// Item channel.
	input  logic           req_valid,
	output logic           req_ready,
	input  hlge_pkg::req_t req,
	// Result channel.
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output hlge_pkg::rsp_t rsp,
	// Configuration writes.
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [8:0]     cfg_data
);
	import hlge_pkg::*;

	// Row index, column index and memory address widths. A memory word is a
	// whole row; the top address bit selects the plane.
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int CW   = $clog2(MAX_COLS);
	localparam int AW   = RW + 1;
	localparam int RCW  = $clog2(MAX_ROWS + 1);
	localparam int CCW  = $clog2(MAX_COLS + 1);
	localparam int RCMP = (RCW > 8) ? RCW : 8;
	localparam int CCMP = (CCW > 9) ? CCW : 9;

	state_t state_q, state_d;

	logic [7:0]      rows_q;
	logic [8:0]      cols_q;
	logic            plane_q;
	logic [AW-1:0]   clr_q;

	// Latched item.
	logic [1:0]      kind_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic            alive_q;
	rsp_t            res_q;

	// Output register.
	logic            rsp_valid_q;
	rsp_t            rsp_q;
	logic            rsp_load;

	// Generation sweep: fetch counter and the stage that holds returned rows.
	logic [RCW-1:0]  fk_q;
	logic            fetch_done_q;
	logic            v_s1;
	logic [RCW-1:0]  k_s1;
	logic [MAX_COLS-1:0] prev_q;
	logic [MAX_COLS-1:0] cur_q;

	// Memory port.
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [MAX_COLS-1:0] mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic [MAX_COLS-1:0] mem_rdata;

	logic [RCMP-1:0] rows_ext, eff_rows;
	logic [CCMP-1:0] cols_ext, eff_cols;
	logic [MAX_COLS-1:0] col_mask;
	logic            req_cell;
	logic            req_in_range;
	logic            req_hit;
	logic [MAX_COLS-1:0] patched;
	logic [MAX_COLS-1:0] row_in;
	logic [MAX_COLS-1:0] rule_row;
	logic            out_row_ok;
	logic [RCW-1:0]  k_m1;
	logic            sweep_last;

	// Registers above the grid limits act as the limits.
	assign rows_ext = RCMP'(rows_q);
	assign cols_ext = CCMP'(cols_q);
	assign eff_rows = (rows_ext > RCMP'(MAX_ROWS)) ? RCMP'(MAX_ROWS) : rows_ext;
	assign eff_cols = (cols_ext > CCMP'(MAX_COLS)) ? CCMP'(MAX_COLS) : cols_ext;

	// Columns in use; the rest of a row always reads and writes as dead.
	for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
		assign col_mask[c] = CCMP'(c) < eff_cols;
	end

	assign req_cell     = (req.kind == KIND_WRITE) || (req.kind == KIND_READ);
	assign req_in_range = (RCMP'(req.row) < eff_rows) && (CCMP'(req.col) < eff_cols);
	assign req_hit      = req_cell && req_in_range;

	// Read-modify-write of one cell within its row word.
	always_comb begin
		patched = mem_rdata;
		patched[col_q] = alive_q;
	end

	// A returned source row, masked to the grid in use. The extra step past
	// the last row finds it beyond the grid and uses an all-dead row.
	assign row_in     = (RCMP'(k_s1) < eff_rows) ? (mem_rdata & col_mask) : '0;
	assign k_m1       = k_s1 - RCW'(1);
	assign out_row_ok = RCMP'(k_s1) <= eff_rows;
	assign sweep_last = v_s1 && (k_s1 == RCW'(MAX_ROWS));

	hlge_row_rule #(
		.COLS (MAX_COLS)
	) u_rule (
		.above (prev_q),
		.mid   (cur_q),
		.below (row_in),
		.nxt   (rule_row)
	);

	hlge_mem #(
		.ADDR_W (AW),
		.DATA_W (MAX_COLS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Controller: next state, handshake and memory port.
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		rsp_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = {plane_q, row_q};
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = {plane_q, RW'(req.row)};
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (&clr_q)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_hit) begin
						mem_re  = 1'b1;
						state_d = ST_ACCESS;
					end else if (req.kind == KIND_STEP) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_ACCESS: begin
				if (kind_q == KIND_WRITE) begin
					mem_we    = 1'b1;
					mem_wdata = patched;
				end
				state_d = ST_FINISH;
			end
			ST_SWEEP: begin
				mem_re    = !fetch_done_q && (fk_q != RCW'(MAX_ROWS));
				mem_raddr = {plane_q, fk_q[RW-1:0]};
				if (v_s1 && (k_s1 != '0)) begin
					mem_we    = 1'b1;
					mem_waddr = {!plane_q, k_m1[RW-1:0]};
					mem_wdata = out_row_ok ? (rule_row & col_mask) : '0;
				end
				if (sweep_last)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q       <= ROWS_RESET;
			cols_q       <= COLS_RESET;
			plane_q      <= 1'b0;
			clr_q        <= '0;
			rsp_valid_q  <= 1'b0;
			fk_q         <= '0;
			fetch_done_q <= 1'b0;
			v_s1         <= 1'b0;
			k_s1         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROWS: rows_q <= cfg_data[7:0];
					CFG_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + AW'(1);
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			// Sweep sequencing: one row fetched per cycle, one stage later
			// it is consumed by the rule unit.
			if (state_q == ST_IDLE) begin
				fk_q         <= '0;
				fetch_done_q <= 1'b0;
				v_s1         <= 1'b0;
			end else if (state_q == ST_SWEEP) begin
				v_s1 <= !fetch_done_q;
				k_s1 <= fk_q;
				if (!fetch_done_q) begin
					if (fk_q == RCW'(MAX_ROWS))
						fetch_done_q <= 1'b1;
					else
						fk_q <= fk_q + RCW'(1);
				end
				if (sweep_last)
					plane_q <= !plane_q;
			end else begin
				v_s1 <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			kind_q             <= req.kind;
			row_q              <= RW'(req.row);
			col_q              <= CW'(req.col);
			alive_q            <= req.alive_in;
			res_q.cell_alive   <= 1'b0;
			res_q.out_of_range <= req_cell && !req_in_range;
			prev_q             <= '0;
			cur_q              <= '0;
		end
		if (state_q == ST_ACCESS && kind_q == KIND_READ)
			res_q.cell_alive <= mem_rdata[col_q];
		if (state_q == ST_SWEEP && v_s1) begin
			prev_q <= cur_q;
			cur_q  <= row_in;
		end
		if (rsp_load)
			rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// The clearing pass writes dead rows on every cycle until it ends.
	a_clear_writes_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (mem_we && (mem_wdata == '0)))
		else $error("clearing pass did not write a dead row");

	// A generation writes only the plane it is not reading.
	a_sweep_dst_plane: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && mem_we) |-> (mem_waddr[AW-1] != plane_q))
		else $error("sweep wrote into the current plane");

	// The plane select changes only at the end of a sweep.
	a_plane_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(plane_q != $past(plane_q)) |-> ($past(state_q) == ST_SWEEP))
		else $error("plane select changed outside a sweep");

	// A flagged access never reports a live cell.
	a_flag_dead: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.cell_alive && rsp.out_of_range))
		else $error("out-of-range result carries a live cell");
`endif

endmodule

@@ sv/hlge_mem.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hlge_mem: row-wide cell store
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read is issued.
// ============================================================================
module hlge_mem #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 256
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/hlge_row_rule.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hlge_row_rule: next generation of one grid row
// Counts the eight neighbors of every column from three masked rows and
// applies the HighLife rule. Columns beyond either edge count as dead.
// ============================================================================
module hlge_row_rule #(
	parameter int COLS = 256
) (
	input  logic [COLS-1:0] above,
	input  logic [COLS-1:0] mid,
	input  logic [COLS-1:0] below,
	output logic [COLS-1:0] nxt
);
	import hlge_pkg::*;

	logic [COLS+1:0] up_p;
	logic [COLS+1:0] mid_p;
	logic [COLS+1:0] dn_p;

	// Padded rows: bit p holds column p-1.
	assign up_p  = {1'b0, above, 1'b0};
	assign mid_p = {1'b0, mid, 1'b0};
	assign dn_p  = {1'b0, below, 1'b0};

	for (genvar c = 0; c < COLS; c++) begin : g_col
		logic [3:0] n;
		assign n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
			+ 4'(mid_p[c]) + 4'(mid_p[c+2])
			+ 4'(dn_p[c]) + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
		assign nxt[c] = hl_next(mid[c], n);
	end

endmodule
